FILE: src/bcre_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcre_pkg
// Types, register map and pixel helpers shared by the cursor row expander.
// ----------------------------------------------------------------------------
package bcre_pkg;

    localparam int CFG_AW    = 5;
    localparam int CFG_DW    = 32;
    localparam int DIM_W     = 7;
    localparam int ROW_W     = 6;
    localparam int RGB_W     = 24;
    localparam int PIX_W     = 32;
    // source sprite row width; sets the plane word width on the input channel
    localparam int SRC_WIDTH = 16;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

    localparam logic [RGB_W-1:0] RST_COLOR_ONE   = 24'h000000;
    localparam logic [RGB_W-1:0] RST_COLOR_TWO   = 24'hffffff;
    localparam logic [RGB_W-1:0] RST_COLOR_THREE = 24'h808080;

    typedef enum logic [2:0] {
        REG_DISPLAY_WIDTH  = 3'd0,
        REG_DISPLAY_HEIGHT = 3'd1,
        REG_BIG_SPRITE     = 3'd2,
        REG_COLOR_ONE      = 3'd3,
        REG_COLOR_TWO      = 3'd4,
        REG_COLOR_THREE    = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        PIX_CLEAR = 2'b00,
        PIX_ONE   = 2'b01,
        PIX_TWO   = 2'b10,
        PIX_THREE = 2'b11
    } t_pix_code;

    typedef struct packed {
        logic [DIM_W-1:0] display_width;
        logic [DIM_W-1:0] display_height;
        logic             big_sprite;
        logic [RGB_W-1:0] color_one;
        logic [RGB_W-1:0] color_two;
        logic [RGB_W-1:0] color_three;
    } t_cfg;

    typedef struct packed {
        logic      valid;
        t_pix_code code;
        logic      last;
    } t_col;

    // opaque ARGB with its four bytes reversed
    function automatic logic [PIX_W-1:0] f_argb_swap(input logic [RGB_W-1:0] rgb);
        return {rgb[7:0], rgb[15:8], rgb[23:16], ALPHA_OPAQUE};
    endfunction

endpackage
`default_nettype wire

FILE: src/bcre_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcre_in_if
// Row request channel: output row index and the two plane words of the row.
// ----------------------------------------------------------------------------
interface bcre_in_if import bcre_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [5:0]           row_index;
    logic [SRC_WIDTH-1:0] plane_low;
    logic [SRC_WIDTH-1:0] plane_high;
    logic                 image_present;

    modport source (
        output valid, row_index, plane_low, plane_high, image_present,
        input  ready
    );
    modport sink (
        input  valid, row_index, plane_low, plane_high, image_present,
        output ready
    );
endinterface
`default_nettype wire

FILE: src/bcre_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcre_out_if
// Pixel channel: one byte-swapped ARGB word per transfer, last flag per row.
// ----------------------------------------------------------------------------
interface bcre_out_if ();
    logic        valid;
    logic        ready;
    logic [31:0] pixel_word;
    logic        last_in_row;

    modport source (
        output valid, pixel_word, last_in_row,
        input  ready
    );
    modport sink (
        input  valid, pixel_word, last_in_row,
        output ready
    );
endinterface
`default_nettype wire

FILE: src/bcre_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcre_cfg
// APB register file: display size, zoom flag and the three pointer colors.
// ----------------------------------------------------------------------------
module bcre_cfg import bcre_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic      [CFG_DW-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[CFG_AW-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.display_width  <= '0;
            r_cfg.display_height <= '0;
            r_cfg.big_sprite     <= 1'b0;
            r_cfg.color_one      <= RST_COLOR_ONE;
            r_cfg.color_two      <= RST_COLOR_TWO;
            r_cfg.color_three    <= RST_COLOR_THREE;
        end else if (w_wr) begin
            case (w_idx)
                REG_DISPLAY_WIDTH:  r_cfg.display_width  <= pwdata[DIM_W-1:0];
                REG_DISPLAY_HEIGHT: r_cfg.display_height <= pwdata[DIM_W-1:0];
                REG_BIG_SPRITE:     r_cfg.big_sprite     <= pwdata[0];
                REG_COLOR_ONE:      r_cfg.color_one      <= pwdata[RGB_W-1:0];
                REG_COLOR_TWO:      r_cfg.color_two      <= pwdata[RGB_W-1:0];
                REG_COLOR_THREE:    r_cfg.color_three    <= pwdata[RGB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_DISPLAY_WIDTH:  prdata = CFG_DW'(r_cfg.display_width);
            REG_DISPLAY_HEIGHT: prdata = CFG_DW'(r_cfg.display_height);
            REG_BIG_SPRITE:     prdata = CFG_DW'(r_cfg.big_sprite);
            REG_COLOR_ONE:      prdata = CFG_DW'(r_cfg.color_one);
            REG_COLOR_TWO:      prdata = CFG_DW'(r_cfg.color_two);
            REG_COLOR_THREE:    prdata = CFG_DW'(r_cfg.color_three);
            default:            prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

FILE: src/bcre_row.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcre_row
// Row register and column sequencer: latches one row of plane bits and
// walks the output columns, producing a plane code per column.
// ----------------------------------------------------------------------------
module bcre_row import bcre_pkg::*; #(
    parameter int OUT_WIDTH  = 64,
    parameter int OUT_HEIGHT = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_adv,
    bcre_in_if.sink   i_in,
    output t_col      o_col
);

    localparam int XW = $clog2(OUT_WIDTH);

    logic [DIM_W-1:0]     w_dw;
    logic [DIM_W-1:0]     w_dh;
    logic                 w_zoom;
    logic [DIM_W-1:0]     w_sw_raw;
    logic [DIM_W-1:0]     w_sw;
    logic [DIM_W-1:0]     w_sh;
    logic [ROW_W-1:0]     w_sy;
    logic                 w_row_vis;
    logic                 w_last;
    logic                 w_accept;
    logic [XW-1:0]        w_sx;
    logic                 w_col_vis;

    logic                 r_busy;
    logic [XW-1:0]        r_x;
    logic [SRC_WIDTH-1:0] r_lo;
    logic [SRC_WIDTH-1:0] r_hi;

    // clamp the display area and derive the source extent
    always_comb begin
        w_dw = (i_cfg.display_width > DIM_W'(OUT_WIDTH)) ?
               DIM_W'(OUT_WIDTH) : i_cfg.display_width;
        w_dh = (i_cfg.display_height > DIM_W'(OUT_HEIGHT)) ?
               DIM_W'(OUT_HEIGHT) : i_cfg.display_height;
        w_zoom = i_cfg.big_sprite || (w_dw > DIM_W'(SRC_WIDTH));
        w_sw_raw = w_zoom ? DIM_W'(({1'b0, w_dw} + 8'd1) >> 1) : w_dw;
        w_sw = (w_sw_raw > DIM_W'(SRC_WIDTH)) ? DIM_W'(SRC_WIDTH) : w_sw_raw;
        w_sh = w_zoom ? DIM_W'(({1'b0, w_dh} + 8'd1) >> 1) : w_dh;
        w_sy = w_zoom ? (i_in.row_index >> 1) : i_in.row_index;
        w_row_vis = i_in.image_present && (DIM_W'(i_in.row_index) < w_dh) &&
                    (DIM_W'(w_sy) < w_sh);
    end

    assign w_last     = (r_x == XW'(OUT_WIDTH - 1));
    assign i_in.ready = !r_busy || (i_adv && w_last);
    assign w_accept   = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
        end else if (i_adv && w_last) begin
            r_busy <= 1'b0;
        end
    end

    // plane words shift out MSB first; under zoom each source pixel lasts two columns
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x  <= '0;
            r_lo <= w_row_vis ? i_in.plane_low  : '0;
            r_hi <= w_row_vis ? i_in.plane_high : '0;
        end else if (r_busy && i_adv) begin
            r_x <= r_x + XW'(1);
            if (!w_zoom || r_x[0]) begin
                r_lo <= {r_lo[SRC_WIDTH-2:0], 1'b0};
                r_hi <= {r_hi[SRC_WIDTH-2:0], 1'b0};
            end
        end
    end

    assign w_sx      = w_zoom ? (r_x >> 1) : r_x;
    assign w_col_vis = (DIM_W'(r_x) < w_dw) && (DIM_W'(w_sx) < w_sw);

    always_comb begin
        o_col.valid = r_busy;
        o_col.last  = w_last;
        o_col.code  = w_col_vis ? t_pix_code'({r_hi[SRC_WIDTH-1], r_lo[SRC_WIDTH-1]})
                                : PIX_CLEAR;
    end

endmodule
`default_nettype wire

FILE: src/bcre_pix.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcre_pix
// Color lookup and output register: maps a plane code to a byte-swapped
// ARGB word and holds it until the sink takes it.
// ----------------------------------------------------------------------------
module bcre_pix import bcre_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire t_col i_col,
    output logic      o_adv,
    bcre_out_if.source o_out
);

    logic             r_valid;
    logic [PIX_W-1:0] r_pixel;
    logic             r_last;
    logic [PIX_W-1:0] n_pixel;

    assign o_adv = !r_valid || o_out.ready;

    always_comb begin
        case (i_col.code)
            PIX_ONE:   n_pixel = f_argb_swap(i_cfg.color_one);
            PIX_TWO:   n_pixel = f_argb_swap(i_cfg.color_two);
            PIX_THREE: n_pixel = f_argb_swap(i_cfg.color_three);
            default:   n_pixel = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_col.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_col.valid) begin
            r_pixel <= n_pixel;
            r_last  <= i_col.last;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.pixel_word  = r_pixel;
    assign o_out.last_in_row = r_last;

endmodule
`default_nettype wire

FILE: src/bitplane_cursor_row_expand.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bitplane_cursor_row_expand
// First pixel word of a row: registered in the row sequencer, then in the
// output register. Throughput: OUT_WIDTH pixel words per row, one per cycle
// while the sink is ready; the next row is taken on the cycle its
// predecessor's last column issues, so rows stream with no gap.
// Reset: synchronous active low; clears the sequencer busy flag and output
// valid and loads the register defaults.
// ----------------------------------------------------------------------------
module bitplane_cursor_row_expand import bcre_pkg::*; #(
    parameter int OUT_WIDTH  = 64,
    parameter int OUT_HEIGHT = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic      [CFG_DW-1:0] prdata,
    output logic                   pready,
    bcre_in_if.sink                i_in,
    bcre_out_if.source             o_out
);

    t_cfg w_cfg;
    t_col w_col;
    logic w_adv;

    bcre_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    bcre_row #(
        .OUT_WIDTH  (OUT_WIDTH),
        .OUT_HEIGHT (OUT_HEIGHT)
    ) u_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_adv   (w_adv),
        .i_in    (i_in),
        .o_col   (w_col)
    );

    bcre_pix u_pix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_col   (w_col),
        .o_adv   (w_adv),
        .o_out   (o_out)
    );

    // a new row starts at column zero, which is never the last column
    a_row_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (w_col.valid && !w_col.last))
        else $error("row did not start at first column");

    // an issued column always lands in the output register
    a_col_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_col.valid && w_adv) |=> o_out.valid)
        else $error("issued column lost");

    // a row is taken while busy only as the last column leaves
    a_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && w_col.valid) |-> (w_adv && w_col.last))
        else $error("row taken mid-row");

endmodule
`default_nettype wire
